### hw/rtl/i2cm_pkg.sv
package i2cm_pkg;

  // Payload store depth, the field widths that follow from it, and the state width.
  localparam int PAYLOAD_DEPTH = 16;
  localparam int IDX_W = 4;
  localparam int LEN_W = 5;
  localparam int STATE_W = 5;

  // Bit counter value at the start of every byte.
  localparam logic [3:0] BIT_COUNT_INIT = 4'd8;
  // Mask that clears the R/W bit of an address byte.
  localparam logic [7:0] RW_CLEAR_MASK = 8'hFE;

  // Item commands.
  typedef enum logic [1:0] {
    CMD_TICK   = 2'd0,
    CMD_LOAD   = 2'd1,
    CMD_SUBMIT = 2'd2
  } cmd_t;

  // Bus states: idle, then one pair of half periods per bus phase.
  typedef enum logic [STATE_W-1:0] {
    S_IDLE    = 5'd0,
    S_START_L = 5'd1,
    S_START_H = 5'd2,
    S_ADDR_L  = 5'd3,
    S_ADDR_H  = 5'd4,
    S_AACK_L  = 5'd5,
    S_AACK_H  = 5'd6,
    S_RD_L    = 5'd7,
    S_RD_H    = 5'd8,
    S_WR_L    = 5'd9,
    S_WR_H    = 5'd10,
    S_MACK_L  = 5'd11,
    S_MACK_H  = 5'd12,
    S_SACK_L  = 5'd13,
    S_SACK_H  = 5'd14,
    S_MNACK_L = 5'd15,
    S_MNACK_H = 5'd16,
    S_STOP_L  = 5'd17,
    S_STOP_H  = 5'd18
  } bus_state_t;

  typedef struct packed {
    logic [1:0]       cmd;
    logic             sda_in;
    logic [7:0]       address_byte;
    logic [LEN_W-1:0] transfer_length;
    logic [IDX_W-1:0] payload_index;
    logic [7:0]       payload_byte;
  } in_item_t;

  typedef struct packed {
    logic               scl_out;
    logic               sda_out;
    logic               busy_res;
    logic               done_res;
    logic               rejected;
    logic [LEN_W-1:0]   bytes_done;
    logic               read_valid;
    logic [7:0]         read_byte;
    logic [IDX_W-1:0]   read_index;
    logic [STATE_W-1:0] phase;
  } out_item_t;

endpackage

### hw/rtl/i2c_master_bit_engine.sv
// An item's result passes from the input register through the bus engine into the result
// register. Throughput: one item per cycle unless a low out_ready stalls the result register;
// the engine's single state update per item sets this.
// Reset (synchronous, rst_n low): both registers empty, lines released high, engine idle
// with bit counter 8; the payload store is not cleared and holds garbage until loaded.
module i2c_master_bit_engine (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  output logic                in_ready,
  input  i2cm_pkg::in_item_t  in_item,
  output logic                out_valid,
  input  logic                out_ready,
  output i2cm_pkg::out_item_t out_item
);
  import i2cm_pkg::*;

  in_item_t  in_item_r;
  logic      in_valid_r;
  out_item_t out_item_r;
  logic      out_valid_r;
  out_item_t result;
  logic      advance;

  // An item moves into the engine whenever the result register can take its result.
  assign advance  = in_valid_r && (!out_valid_r || out_ready);
  assign in_ready = !in_valid_r || advance;

  i2cm_core u_core (
    .clk    (clk),
    .rst_n  (rst_n),
    .step   (advance),
    .item   (in_item_r),
    .result (result)
  );

  // Input register.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_valid_r <= 1'b0;
    end else if (in_ready) begin
      in_valid_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_ready && in_valid) begin
      in_item_r <= in_item;
    end
  end

  // Result register.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (advance) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      out_item_r <= result;
    end
  end

  assign out_valid = out_valid_r;
  assign out_item  = out_item_r;

endmodule

### hw/rtl/i2cm_core.sv
module i2cm_core (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               step,
  input  i2cm_pkg::in_item_t item,
  output i2cm_pkg::out_item_t result
);
  import i2cm_pkg::*;

  // Engine state.
  bus_state_t       state_r, state_nxt;
  logic [3:0]       bit_cnt_r, bit_cnt_nxt;
  logic [7:0]       shift_r, shift_nxt;
  logic [LEN_W-1:0] byte_cnt_r, byte_cnt_nxt;
  logic [7:0]       held_addr_r, held_addr_nxt;
  logic [LEN_W-1:0] held_len_r, held_len_nxt;
  logic [1:0]       pending_r, pending_nxt;
  logic             dummy_r, dummy_nxt;
  logic             scl_r, scl_nxt;
  logic             sda_r, sda_nxt;
  logic             busy_r, busy_nxt;

  // Payload store, written by loads and by received bytes.
  logic [7:0]       store_mem [PAYLOAD_DEPTH];
  logic             store_we;
  logic [IDX_W-1:0] store_wa;
  logic [7:0]       store_wd;
  logic [LEN_W-1:0] store_ra;
  logic [7:0]       store_rd;

  // Derived values of the current phase.
  logic [7:0]       cur_addr;
  logic [LEN_W-1:0] cur_len;
  logic [LEN_W-1:0] byte_cnt_inc;
  logic [1:0]       pending_dec;
  logic [LEN_W-1:0] len_clamped;
  logic [7:0]       rd_shift;
  logic             done;
  logic             rej;
  logic             rvalid;

  assign cur_addr     = dummy_r ? (held_addr_r & RW_CLEAR_MASK) : held_addr_r;
  assign cur_len      = dummy_r ? LEN_W'(1) : held_len_r;
  assign byte_cnt_inc = byte_cnt_r + LEN_W'(1);
  assign pending_dec  = (pending_r != 2'd0) ? (pending_r - 2'd1) : 2'd0;
  assign rd_shift     = {shift_r[6:0], item.sda_in};

  // Single read port: the slave ACK state looks one byte ahead.
  assign store_ra = (state_r == S_SACK_H) ? byte_cnt_inc : byte_cnt_r;
  assign store_rd = (store_ra < LEN_W'(PAYLOAD_DEPTH)) ? store_mem[store_ra[IDX_W-1:0]]
                                                       : 8'd0;

  // Submitted length is forced into the range of the store.
  always_comb begin
    if (item.transfer_length == '0) begin
      len_clamped = LEN_W'(1);
    end else if (item.transfer_length > LEN_W'(PAYLOAD_DEPTH)) begin
      len_clamped = LEN_W'(PAYLOAD_DEPTH);
    end else begin
      len_clamped = item.transfer_length;
    end
  end

  // Next state for one item.
  always_comb begin
    state_nxt     = state_r;
    bit_cnt_nxt   = bit_cnt_r;
    shift_nxt     = shift_r;
    byte_cnt_nxt  = byte_cnt_r;
    held_addr_nxt = held_addr_r;
    held_len_nxt  = held_len_r;
    pending_nxt   = pending_r;
    dummy_nxt     = dummy_r;
    scl_nxt       = scl_r;
    sda_nxt       = sda_r;
    busy_nxt      = busy_r;
    done          = 1'b0;
    rej           = 1'b0;
    rvalid        = 1'b0;
    store_we      = 1'b0;
    store_wa      = item.payload_index;
    store_wd      = item.payload_byte;

    case (item.cmd)
      CMD_LOAD: begin
        store_we = 1'b1;
      end
      CMD_SUBMIT: begin
        if (busy_r) begin
          rej = 1'b1;
        end else begin
          held_addr_nxt = item.address_byte;
          held_len_nxt  = len_clamped;
          dummy_nxt     = item.address_byte[0];
          pending_nxt   = item.address_byte[0] ? 2'd2 : 2'd1;
          bit_cnt_nxt   = BIT_COUNT_INIT;
          byte_cnt_nxt  = '0;
          shift_nxt     = item.address_byte[0] ? (item.address_byte & RW_CLEAR_MASK)
                                               : item.address_byte;
          state_nxt     = S_START_L;
          scl_nxt       = 1'b1;
          sda_nxt       = 1'b1;
          busy_nxt      = 1'b1;
        end
      end
      CMD_TICK: begin
        if (busy_r) begin
          scl_nxt = ~scl_r;
          case (state_r)
            S_IDLE: begin
              sda_nxt  = 1'b1;
              scl_nxt  = 1'b1;
              busy_nxt = 1'b0;
              done     = 1'b1;
            end
            S_START_L: begin
              sda_nxt   = 1'b1;
              state_nxt = S_START_H;
            end
            S_START_H: begin
              sda_nxt   = 1'b0;
              shift_nxt = cur_addr;
              state_nxt = S_ADDR_L;
            end
            S_ADDR_L, S_WR_L: begin
              sda_nxt     = shift_r[7];
              bit_cnt_nxt = bit_cnt_r - 4'd1;
              state_nxt   = (state_r == S_ADDR_L) ? S_ADDR_H : S_WR_H;
            end
            S_ADDR_H, S_WR_H: begin
              if (bit_cnt_r == 4'd0) begin
                bit_cnt_nxt = BIT_COUNT_INIT;
                state_nxt   = (state_r == S_ADDR_H) ? S_AACK_L : S_SACK_L;
              end else begin
                shift_nxt = {shift_r[6:0], 1'b0};
                state_nxt = (state_r == S_ADDR_H) ? S_ADDR_L : S_WR_L;
              end
            end
            S_AACK_L, S_SACK_L: begin
              sda_nxt   = 1'b1;
              state_nxt = (state_r == S_AACK_L) ? S_AACK_H : S_SACK_H;
            end
            S_AACK_H: begin
              if (!item.sda_in) begin
                state_nxt = cur_addr[0] ? S_RD_L : S_WR_L;
                shift_nxt = store_rd;
              end else begin
                pending_nxt = 2'd0;
                state_nxt   = S_STOP_L;
              end
            end
            S_RD_L: begin
              sda_nxt     = 1'b1;
              bit_cnt_nxt = bit_cnt_r - 4'd1;
              state_nxt   = S_RD_H;
            end
            S_RD_H: begin
              shift_nxt = rd_shift;
              if (bit_cnt_r == 4'd0) begin
                bit_cnt_nxt = BIT_COUNT_INIT;
                // Received byte goes back into the store at its slot.
                if (byte_cnt_r < LEN_W'(PAYLOAD_DEPTH)) begin
                  store_we = 1'b1;
                end
                store_wa     = byte_cnt_r[IDX_W-1:0];
                store_wd     = rd_shift;
                rvalid       = 1'b1;
                byte_cnt_nxt = byte_cnt_inc;
                state_nxt    = (byte_cnt_inc == cur_len) ? S_MNACK_L : S_MACK_L;
              end else begin
                state_nxt = S_RD_L;
              end
            end
            S_MACK_L: begin
              sda_nxt   = 1'b0;
              state_nxt = S_MACK_H;
            end
            S_MACK_H: begin
              state_nxt = S_RD_L;
            end
            S_SACK_H: begin
              if (!item.sda_in) begin
                byte_cnt_nxt = byte_cnt_inc;
                if (byte_cnt_inc >= cur_len) begin
                  // Phase done: either the read phase follows or a stop.
                  pending_nxt = pending_dec;
                  if (pending_dec != 2'd0) begin
                    dummy_nxt    = 1'b0;
                    byte_cnt_nxt = '0;
                    shift_nxt    = held_addr_r;
                    state_nxt    = S_START_L;
                  end else begin
                    state_nxt = S_STOP_L;
                  end
                end else begin
                  shift_nxt = store_rd;
                  state_nxt = S_WR_L;
                end
              end else begin
                pending_nxt = 2'd0;
                state_nxt   = S_STOP_L;
              end
            end
            S_MNACK_L: begin
              sda_nxt   = 1'b1;
              state_nxt = S_MNACK_H;
            end
            S_MNACK_H: begin
              pending_nxt = pending_dec;
              if (pending_dec != 2'd0) begin
                dummy_nxt    = 1'b0;
                byte_cnt_nxt = '0;
                shift_nxt    = held_addr_r;
                state_nxt    = S_START_L;
              end else begin
                state_nxt = S_STOP_L;
              end
            end
            S_STOP_L: begin
              sda_nxt   = 1'b0;
              state_nxt = S_STOP_H;
            end
            S_STOP_H: begin
              sda_nxt   = 1'b1;
              state_nxt = S_IDLE;
            end
            default: begin
              state_nxt = S_IDLE;
            end
          endcase
        end
      end
      default: begin
      end
    endcase
  end

  // Result of this item, taken from the updated state.
  always_comb begin
    result.scl_out    = scl_nxt;
    result.sda_out    = sda_nxt;
    result.busy_res   = busy_nxt;
    result.done_res   = done;
    result.rejected   = rej;
    result.bytes_done = byte_cnt_nxt;
    result.read_valid = rvalid;
    result.read_byte  = rvalid ? rd_shift : 8'd0;
    result.read_index = rvalid ? byte_cnt_r[IDX_W-1:0] : '0;
    result.phase      = state_nxt;
  end

  // State registers.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      bit_cnt_r   <= BIT_COUNT_INIT;
      shift_r     <= 8'd0;
      byte_cnt_r  <= '0;
      held_addr_r <= 8'd0;
      held_len_r  <= '0;
      pending_r   <= 2'd0;
      dummy_r     <= 1'b0;
      scl_r       <= 1'b1;
      sda_r       <= 1'b1;
      busy_r      <= 1'b0;
    end else if (step) begin
      state_r     <= state_nxt;
      bit_cnt_r   <= bit_cnt_nxt;
      shift_r     <= shift_nxt;
      byte_cnt_r  <= byte_cnt_nxt;
      held_addr_r <= held_addr_nxt;
      held_len_r  <= held_len_nxt;
      pending_r   <= pending_nxt;
      dummy_r     <= dummy_nxt;
      scl_r       <= scl_nxt;
      sda_r       <= sda_nxt;
      busy_r      <= busy_nxt;
    end
  end

  // Store write port.
  always_ff @(posedge clk) begin
    if (step && store_we) begin
      store_mem[store_wa] <= store_wd;
    end
  end

endmodule
